### rtl/core/lz4bd_pkg.sv
// Shared types and constants for the LZ4 block decompressor.
package lz4bd_pkg;

  localparam int HistAw = 16;
  localparam int LenW   = 23;
  localparam int CntW   = 24;

  // configuration register indexes
  localparam logic REG_MAX_BLOCK_CODE = 1'b0;
  localparam logic REG_INDEPENDENT    = 1'b1;

  // error codes
  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_EMPTY     = 4'd1;
  localparam logic [3:0] ERR_SHORT_TOK = 4'd2;
  localparam logic [3:0] ERR_OUT_OVF   = 4'd3;
  localparam logic [3:0] ERR_LIT_OVR   = 4'd4;
  localparam logic [3:0] ERR_BAD_FINAL = 4'd5;
  localparam logic [3:0] ERR_ZERO_DIST = 4'd6;
  localparam logic [3:0] ERR_FAR_DIST  = 4'd7;
  localparam logic [3:0] ERR_NO_FINAL  = 4'd8;
  localparam logic [3:0] ERR_TOO_BIG   = 4'd9;

  typedef enum logic [3:0] {
    PH_IDLE, PH_STORED, PH_SHORT_TOK, PH_TOKEN, PH_LITLEN, PH_LIT,
    PH_FINAL_LIT, PH_DIST0, PH_DIST1, PH_MLEN, PH_MATCH, PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    K_START = 2'd0,
    K_BYTE  = 2'd1,
    K_DRAIN = 2'd2,
    K_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [7:0]      data_byte;
    logic [LenW-1:0] block_length;
    logic            stored_block;
  } item_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic  vld;
    item_t item;
  } q_head_t;

endpackage

### rtl/core/lz4bd_front.sv
// Front end: accepts input beats, classifies them and queues them.
module lz4bd_front
  import lz4bd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // data_byte, block_length, stored_block
  input  logic [1:0]  in_tuser,   // action
  output q_head_t     head,
  input  logic        pop
);

  item_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      cls;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;

  // classify the beat
  always_comb begin
    cls.kind         = kind_t'(in_tuser);
    cls.data_byte    = in_tdata[7:0];
    cls.block_length = in_tdata[30:8];
    cls.stored_block = in_tdata[31];
  end

  assign head.vld  = (cnt_r != 2'd0);
  assign head.item = q_r[rd_ptr_r];

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cls;
  end

endmodule

### rtl/core/lz4bd_back.sv
// Back end: sequence parser, history store and output register.
module lz4bd_back
  import lz4bd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [2:0]  cfg_wdata,
  input  q_head_t     head,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata
);

  typedef struct packed {
    phase_t     ph;
    logic [3:0] err;
    logic       done;
  } lk_t;

  // parser state
  phase_t            phase_r, phase_nxt;
  logic [HistAw-1:0] wpos_r, wpos_nxt;
  logic [HistAw-1:0] fill_r, fill_nxt;
  logic [LenW-1:0]   ileft_r, ileft_nxt;
  logic [LenW-1:0]   ocnt_r, ocnt_nxt;
  logic [CntW-1:0]   lleft_r, lleft_nxt;
  logic [CntW-1:0]   mleft_r, mleft_nxt;
  logic [HistAw-1:0] dist_r, dist_nxt;
  logic [3:0]        err_r, err_nxt;
  logic [2:0]        code_r;
  logic              indep_r;

  // output stage
  logic              s2_vld_r, s2_lit_r, s2_mat_r, s2_pend_r, s2_done_r;
  logic [7:0]        s2_byte_r;
  logic [HistAw-1:0] s2_addr_r, s2_src_r;
  logic [3:0]        s2_err_r;
  logic [7:0]        rd_r;
  logic [HistAw-1:0] last_addr_r;
  logic [7:0]        last_byte_r;
  logic              last_vld_r;

  logic [7:0]        hist [1 << HistAw];

  logic              adv, emit_lit, emit_mat, done;
  logic [CntW-1:0]   lim, room, ll2, ml2;
  logic [LenW-1:0]   idec;
  logic [HistAw-1:0] dnew, src;
  logic [7:0]        b;
  logic [7:0]        byte_fin;
  logic              wr_en;
  lk_t               lk;

  // tail check once the literal count of a sequence is known
  function automatic lk_t lits_known(input logic [CntW-1:0] copy,
                                     input logic [CntW-1:0] rm,
                                     input logic [LenW-1:0] il,
                                     input logic [CntW-1:0] ml);
    lk_t r;
    r.ph   = PH_HALT;
    r.err  = ERR_NONE;
    r.done = 1'b0;
    if (rm < copy) begin
      r.err = ERR_OUT_OVF;
    end else if ({2'b0, il} < {1'b0, copy} + 25'd8) begin
      if ({1'b0, il} != copy || ml != '0) r.err = ERR_BAD_FINAL;
      else if (copy == '0) begin
        r.ph   = PH_IDLE;
        r.done = 1'b1;
      end else r.ph = PH_FINAL_LIT;
    end else begin
      r.ph = (copy != '0) ? PH_LIT : PH_DIST0;
    end
    return r;
  endfunction

  assign adv = !s2_vld_r || out_tready;
  assign pop = head.vld && adv;
  assign b   = head.item.data_byte;
  assign lim  = CntW'(256) << {code_r, 1'b0};
  assign room = lim - {1'b0, ocnt_r};
  assign idec = ileft_r - 1'b1;
  assign ll2  = lleft_r + {16'd0, b};
  assign ml2  = mleft_r + {16'd0, b};
  assign dnew = {b, dist_r[7:0]};
  assign src  = wpos_r - dist_r;
  assign lk   = lits_known({20'd0, b[7:4]}, room, idec, {20'd0, b[3:0]});

  // next state of the parser
  always_comb begin
    phase_nxt = phase_r;
    ileft_nxt = ileft_r;
    lleft_nxt = lleft_r;
    mleft_nxt = mleft_r;
    dist_nxt  = dist_r;
    err_nxt   = err_r;
    ocnt_nxt  = ocnt_r;
    fill_nxt  = fill_r;
    wpos_nxt  = wpos_r;
    emit_lit  = 1'b0;
    emit_mat  = 1'b0;
    done      = 1'b0;
    if (pop) begin
      case (head.item.kind)
        K_START: begin
          if (indep_r) fill_nxt = '0;
          err_nxt   = ERR_NONE;
          ocnt_nxt  = '0;
          lleft_nxt = '0;
          mleft_nxt = '0;
          dist_nxt  = '0;
          ileft_nxt = head.item.block_length;
          if (head.item.block_length == '0) begin
            err_nxt = ERR_EMPTY; phase_nxt = PH_HALT;
          end else if ({1'b0, head.item.block_length} > lim) begin
            err_nxt = ERR_TOO_BIG; phase_nxt = PH_HALT;
          end else if (head.item.stored_block) phase_nxt = PH_STORED;
          else if (head.item.block_length < LenW'(6)) phase_nxt = PH_SHORT_TOK;
          else phase_nxt = PH_TOKEN;
        end
        K_BYTE: begin
          if (ileft_r != '0) begin
            case (phase_r)
              PH_STORED: begin
                ileft_nxt = idec;
                emit_lit  = 1'b1;
                if (idec == '0) begin
                  done = 1'b1; phase_nxt = PH_IDLE;
                end
              end
              PH_SHORT_TOK: begin
                ileft_nxt = idec;
                lleft_nxt = {20'd0, b[7:4]};
                if (idec[LenW-1:4] != '0 || b != {idec[3:0], 4'h0}) begin
                  err_nxt = ERR_SHORT_TOK; phase_nxt = PH_HALT;
                end else if (room < {20'd0, b[7:4]}) begin
                  err_nxt = ERR_OUT_OVF; phase_nxt = PH_HALT;
                end else if (b[7:4] == 4'd0) begin
                  done = 1'b1; phase_nxt = PH_IDLE;
                end else phase_nxt = PH_FINAL_LIT;
              end
              PH_TOKEN: begin
                ileft_nxt = idec;
                lleft_nxt = {20'd0, b[7:4]};
                mleft_nxt = {20'd0, b[3:0]};
                if (b[7:4] == 4'hf) phase_nxt = PH_LITLEN;
                else begin
                  phase_nxt = lk.ph;
                  if (lk.ph == PH_HALT) err_nxt = lk.err;
                  done = lk.done;
                end
              end
              PH_LITLEN: begin
                ileft_nxt = idec;
                lleft_nxt = ll2;
                if ({1'b0, idec} < ll2) begin
                  err_nxt = ERR_LIT_OVR; phase_nxt = PH_HALT;
                end else if (b != 8'hff) begin
                  lk_t k;
                  k = lits_known(ll2, room, idec, mleft_r);
                  phase_nxt = k.ph;
                  if (k.ph == PH_HALT) err_nxt = k.err;
                  done = k.done;
                end
              end
              PH_LIT, PH_FINAL_LIT: begin
                ileft_nxt = idec;
                emit_lit  = 1'b1;
                lleft_nxt = lleft_r - 1'b1;
                if (lleft_r == CntW'(1)) begin
                  if (phase_r == PH_FINAL_LIT) begin
                    done = 1'b1; phase_nxt = PH_IDLE;
                  end else phase_nxt = PH_DIST0;
                end
              end
              PH_DIST0: begin
                ileft_nxt = idec;
                dist_nxt  = {8'd0, b};
                phase_nxt = PH_DIST1;
              end
              PH_DIST1: begin
                ileft_nxt = idec;
                dist_nxt  = dnew;
                mleft_nxt = mleft_r + CntW'(4);
                phase_nxt = PH_HALT;
                if (dnew == '0) err_nxt = ERR_ZERO_DIST;
                else if (dnew > fill_r) err_nxt = ERR_FAR_DIST;
                else if (room < mleft_r + CntW'(9)) err_nxt = ERR_OUT_OVF;
                else if (mleft_r == CntW'(15)) phase_nxt = PH_MLEN;
                else if (idec < LenW'(6)) err_nxt = ERR_NO_FINAL;
                else phase_nxt = PH_MATCH;
              end
              PH_MLEN: begin
                ileft_nxt = idec;
                mleft_nxt = ml2;
                if (room - CntW'(5) < ml2) begin
                  err_nxt = ERR_OUT_OVF; phase_nxt = PH_HALT;
                end else if (idec < LenW'(6)) begin
                  err_nxt = ERR_NO_FINAL; phase_nxt = PH_HALT;
                end else if (b != 8'hff) phase_nxt = PH_MATCH;
              end
              default: ;
            endcase
          end
        end
        K_DRAIN: begin
          if (phase_r == PH_MATCH && mleft_r != '0) begin
            emit_mat  = 1'b1;
            mleft_nxt = mleft_r - 1'b1;
            if (mleft_r == CntW'(1)) phase_nxt = PH_TOKEN;
          end
        end
        default: ;
      endcase
      // every emitted byte advances the window
      if (emit_lit || emit_mat) begin
        wpos_nxt = wpos_r + 1'b1;
        ocnt_nxt = ocnt_r + 1'b1;
        if (fill_nxt != '1) fill_nxt = fill_nxt + 1'b1;
      end
    end
  end

  // parser and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      wpos_r  <= '0;
      fill_r  <= '0;
      ileft_r <= '0;
      ocnt_r  <= '0;
      lleft_r <= '0;
      mleft_r <= '0;
      dist_r  <= '0;
      err_r   <= ERR_NONE;
      code_r  <= 3'd7;
      indep_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      wpos_r  <= wpos_nxt;
      fill_r  <= fill_nxt;
      ileft_r <= ileft_nxt;
      ocnt_r  <= ocnt_nxt;
      lleft_r <= lleft_nxt;
      mleft_r <= mleft_nxt;
      dist_r  <= dist_nxt;
      err_r   <= err_nxt;
      if (cfg_we && cfg_addr == REG_MAX_BLOCK_CODE) code_r <= cfg_wdata;
      if (cfg_we && cfg_addr == REG_INDEPENDENT) indep_r <= cfg_wdata[0];
    end
  end

  // output stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r   <= 1'b0;
      last_vld_r <= 1'b0;
    end else begin
      if (adv) s2_vld_r <= pop;
      if (wr_en) last_vld_r <= 1'b1;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      s2_lit_r  <= emit_lit;
      s2_mat_r  <= emit_mat;
      s2_byte_r <= b;
      s2_addr_r <= wpos_r;
      s2_src_r  <= src;
      s2_pend_r <= (phase_nxt == PH_MATCH) && (mleft_nxt != '0);
      s2_done_r <= done;
      s2_err_r  <= err_nxt;
    end
    if (wr_en) begin
      last_addr_r <= s2_addr_r;
      last_byte_r <= byte_fin;
    end
  end

  // history store: read on issue, write on delivery
  always_ff @(posedge clk) begin
    if (pop && emit_mat) rd_r <= hist[src];
    if (wr_en) hist[s2_addr_r] <= byte_fin;
  end

  // the last write may not be in the store yet when it was read
  always_comb begin
    if (s2_lit_r) byte_fin = s2_byte_r;
    else if (last_vld_r && last_addr_r == s2_src_r) byte_fin = last_byte_r;
    else byte_fin = rd_r;
  end

  assign wr_en      = s2_vld_r && out_tready && (s2_lit_r || s2_mat_r);
  assign out_tvalid = s2_vld_r;
  assign out_tdata  = {1'b0, s2_err_r, s2_done_r, s2_pend_r,
                       (s2_lit_r || s2_mat_r) ? byte_fin : 8'd0,
                       s2_lit_r || s2_mat_r};

endmodule

### rtl/core/lz4_block_decompressor.sv
// LZ4 block decompressor top level.
// An input beat is held in the front queue register, then in the output stage register, before its result beat.
// Throughput: one beat per cycle while the output is not stalled, bytes and drain ticks alike; set by the
// single-write, single-read port of the 64 KiB history memory.
// Reset (rst_n, synchronous): parser idle, counters and errors cleared,
// max_block_code 7, independent_blocks 0; history content is left as is.
module lz4_block_decompressor
  import lz4bd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // data_byte[7:0], block_length[30:8], stored_block[31]
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // out_valid, out_byte, match_pending, block_done, error_code
);

  q_head_t head;
  logic    pop;

  lz4bd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .pop       (pop)
  );

  lz4bd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef ASSERT_OFF
  // a decoded byte never comes with an error
  a_byte_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[14:11] == ERR_NONE)
    else $error("byte emitted with error set");

  // a finished block has no error and no match left
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[14:11] == ERR_NONE && !out_tdata[9])
    else $error("block done with error or pending match");

  // no byte, no byte value
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[8:1] == 8'd0)
    else $error("byte value without valid");
`endif

endmodule
